// ----- rtl/core/ile_pkg.sv -----
// ile_pkg: shared types and codes of the indexed list engine
// depends on nothing; used by the interfaces, the controller and the top level

package ile_pkg;

	// operation codes
	localparam logic [2:0] CMD_READ       = 3'd0;
	localparam logic [2:0] CMD_INS_HEAD   = 3'd1;
	localparam logic [2:0] CMD_INS_TAIL   = 3'd2;
	localparam logic [2:0] CMD_INS_BEFORE = 3'd3;
	localparam logic [2:0] CMD_DELETE     = 3'd4;

	// result status codes
	localparam logic [1:0] ST_DONE    = 2'd0;
	localparam logic [1:0] ST_INVALID = 2'd1;
	localparam logic [1:0] ST_FULL    = 2'd2;

	// field widths of one transaction
	localparam int CMD_W   = 3;
	localparam int POS_W   = 16;
	localparam int VAL_W   = 32;
	localparam int STAT_W  = 2;
	localparam int LCNT_W  = 5;

	localparam logic signed [VAL_W-1:0] VAL_NONE = -32'sd1;

	// one result as produced by the controller
	typedef struct packed {
		logic signed [VAL_W-1:0] read_value;
		logic [STAT_W-1:0]       status;
		logic [LCNT_W-1:0]       list_count;
	} ile_result_t;

endpackage

// ----- rtl/core/ile_if.sv -----
// ile_in_if / ile_out_if: valid/ready channels of the indexed list engine
// depends on ile_pkg for field widths

interface ile_in_if
	import ile_pkg::*;
();
	logic                    valid;
	logic                    ready;
	logic [CMD_W-1:0]        cmd;
	logic signed [POS_W-1:0] position;
	logic signed [VAL_W-1:0] data_in;

	modport source (output valid, output cmd, output position, output data_in, input ready);
	modport sink (input valid, input cmd, input position, input data_in, output ready);
endinterface

interface ile_out_if
	import ile_pkg::*;
();
	logic                    valid;
	logic                    ready;
	logic signed [VAL_W-1:0] read_value;
	logic [STAT_W-1:0]       status;
	logic [LCNT_W-1:0]       list_count;

	modport source (output valid, output read_value, output status, output list_count,
		input ready);
	modport sink (input valid, input read_value, input status, input list_count,
		output ready);
endinterface

// ----- rtl/core/ile_mem.sv -----
// ile_mem: element store, one write port and one read port, registered read data
// depends on nothing

module ile_mem #(
	parameter int DEPTH = 16,
	parameter int WIDTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// read port, registered read data
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ----- rtl/core/ile_ctrl.sv -----
// ile_ctrl: operation sequencer, decodes a transaction and walks the store
// depends on ile_pkg and ile_in_if; drives the ports of ile_mem

module ile_ctrl
	import ile_pkg::*;
#(
	parameter int CAPACITY   = 16,
	parameter int DATA_WIDTH = 32
) (
	input  logic                        clk,
	input  logic                        arst_n,
	ile_in_if.sink                      req,
	output logic                        mem_we,
	output logic [$clog2(CAPACITY)-1:0] mem_waddr,
	output logic [DATA_WIDTH-1:0]       mem_wdata,
	output logic                        mem_re,
	output logic [$clog2(CAPACITY)-1:0] mem_raddr,
	input  logic [DATA_WIDTH-1:0]       mem_rdata,
	output ile_result_t                 res,
	output logic                        res_valid,
	input  logic                        res_ready
);

	localparam int IDX_W = $clog2(CAPACITY);
	localparam int CNT_W = $clog2(CAPACITY + 1);

	typedef enum logic [2:0] {
		S_IDLE,
		S_DECODE,
		S_RD_WAIT,
		S_SHIFT_UP,
		S_SHIFT_DN,
		S_DONE
	} state_t;

	state_t                  state_q;
	logic [CMD_W-1:0]        cmd_q;
	logic signed [POS_W-1:0] pos_q;
	logic signed [VAL_W-1:0] data_q;
	logic [CNT_W-1:0]        count_q;
	logic [CNT_W-1:0]        ptr_q;
	logic [CNT_W-1:0]        tgt_q;
	logic                    pend_s1;
	logic [IDX_W-1:0]        waddr_s1;
	ile_result_t             res_q;

	logic [POS_W-1:0] pos_mag;
	logic [POS_W-1:0] cnt_ext;
	logic             pos_neg;
	logic             pos_in_list;
	logic             pos_past_end;
	logic             list_full;
	logic [CNT_W-1:0] ins_tgt;
	logic [CNT_W-1:0] ptr_dec;
	logic [CNT_W-1:0] ptr_inc;
	logic [DATA_WIDTH-1:0] ins_value;

	assign req.ready = (state_q == S_IDLE);
	assign res       = res_q;
	assign res_valid = (state_q == S_DONE);

	// position checks against the current count
	always_comb begin
		pos_neg      = pos_q[POS_W-1];
		pos_mag      = {1'b0, pos_q[POS_W-2:0]};
		cnt_ext      = POS_W'(count_q);
		pos_in_list  = !pos_neg && (pos_mag < cnt_ext);
		pos_past_end = !pos_neg && (pos_mag > cnt_ext);
		list_full    = (count_q == CNT_W'(CAPACITY));
		ptr_dec      = ptr_q - CNT_W'(1);
		ptr_inc      = ptr_q + CNT_W'(1);
		ins_value    = DATA_WIDTH'(data_q);
	end

	// insert target position
	always_comb begin
		unique case (cmd_q)
			CMD_INS_TAIL:   ins_tgt = count_q;
			CMD_INS_BEFORE: ins_tgt = pos_neg ? '0 : CNT_W'(pos_mag);
			default:        ins_tgt = '0;
		endcase
	end

	// memory port control
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = waddr_s1;
		mem_wdata = mem_rdata;
		mem_re    = 1'b0;
		mem_raddr = pos_q[IDX_W-1:0];
		unique case (state_q)
			S_DECODE: begin
				mem_re = (cmd_q == CMD_READ) && pos_in_list;
			end
			S_SHIFT_UP: begin
				// move entry ptr-1 up to ptr, then drop the new value at the target
				if (pend_s1) begin
					mem_we = 1'b1;
				end else if (ptr_q == tgt_q) begin
					mem_we    = 1'b1;
					mem_waddr = tgt_q[IDX_W-1:0];
					mem_wdata = ins_value;
				end
				if (ptr_q > tgt_q) begin
					mem_re    = 1'b1;
					mem_raddr = ptr_dec[IDX_W-1:0];
				end
			end
			S_SHIFT_DN: begin
				// move entry ptr+1 down to ptr
				mem_we = pend_s1;
				if (ptr_inc < count_q) begin
					mem_re    = 1'b1;
					mem_raddr = ptr_inc[IDX_W-1:0];
				end
			end
			default: begin
			end
		endcase
	end

	// sequencer state and registered result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			count_q  <= '0;
			pend_s1  <= 1'b0;
			cmd_q    <= '0;
			pos_q    <= '0;
			data_q   <= '0;
			ptr_q    <= '0;
			tgt_q    <= '0;
			waddr_s1 <= '0;
			res_q    <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (req.valid) begin
						cmd_q   <= req.cmd;
						pos_q   <= req.position;
						data_q  <= req.data_in;
						state_q <= S_DECODE;
					end
				end
				S_DECODE: begin
					pend_s1 <= 1'b0;
					res_q   <= '{read_value: VAL_NONE, status: ST_INVALID,
						list_count: LCNT_W'(count_q)};
					state_q <= S_DONE;
					unique case (cmd_q)
						CMD_READ: begin
							if (pos_in_list) begin
								state_q <= S_RD_WAIT;
							end
						end
						CMD_INS_HEAD, CMD_INS_TAIL, CMD_INS_BEFORE: begin
							if (cmd_q == CMD_INS_BEFORE && pos_past_end) begin
								state_q <= S_DONE;
							end else if (list_full) begin
								res_q.status <= ST_FULL;
							end else begin
								tgt_q   <= ins_tgt;
								ptr_q   <= count_q;
								state_q <= S_SHIFT_UP;
							end
						end
						CMD_DELETE: begin
							if (pos_in_list) begin
								ptr_q   <= CNT_W'(pos_mag);
								state_q <= S_SHIFT_DN;
							end
						end
						default: begin
						end
					endcase
				end
				S_RD_WAIT: begin
					res_q.read_value <= VAL_W'($signed(mem_rdata));
					res_q.status     <= ST_DONE;
					state_q          <= S_DONE;
				end
				S_SHIFT_UP: begin
					pend_s1  <= (ptr_q > tgt_q);
					waddr_s1 <= ptr_q[IDX_W-1:0];
					if (ptr_q > tgt_q) begin
						ptr_q <= ptr_dec;
					end else if (!pend_s1) begin
						count_q          <= count_q + CNT_W'(1);
						res_q.status     <= ST_DONE;
						res_q.list_count <= LCNT_W'(count_q + CNT_W'(1));
						state_q          <= S_DONE;
					end
				end
				S_SHIFT_DN: begin
					if (ptr_inc < count_q) begin
						pend_s1  <= 1'b1;
						waddr_s1 <= ptr_q[IDX_W-1:0];
						ptr_q    <= ptr_inc;
					end else begin
						pend_s1 <= 1'b0;
						if (!pend_s1) begin
							count_q          <= ptr_q;
							res_q.status     <= ST_DONE;
							res_q.list_count <= LCNT_W'(ptr_q);
							state_q          <= S_DONE;
						end
					end
				end
				S_DONE: begin
					if (res_ready) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

// ----- rtl/core/indexed_list_engine.sv -----
// indexed_list_engine: ordered list of up to CAPACITY values kept packed in one store
// a read waits on a store read, an ignored or refused op answers from decode, an insert
// before p first moves entries p..count-1 up one place, a delete at p moves the entries
// after p down a place; one transaction at a time, the next can be taken in the cycle
// after the result goes to the output register; the store walk is one entry per cycle
// reset clears the count and the handshake state; store contents are not cleared
//
// depends on ile_pkg, ile_in_if, ile_out_if, ile_mem and ile_ctrl

module indexed_list_engine
	import ile_pkg::*;
#(
	parameter int CAPACITY   = 16,
	parameter int DATA_WIDTH = 32
) (
	input  logic      clk,
	input  logic      arst_n,
	ile_in_if.sink    req,
	ile_out_if.source rsp
);

	localparam int IDX_W = $clog2(CAPACITY);

	logic                  mem_we;
	logic [IDX_W-1:0]      mem_waddr;
	logic [DATA_WIDTH-1:0] mem_wdata;
	logic                  mem_re;
	logic [IDX_W-1:0]      mem_raddr;
	logic [DATA_WIDTH-1:0] mem_rdata;

	ile_result_t res;
	logic        res_valid;
	logic        res_ready;

	logic        out_valid_q;
	ile_result_t out_q;

	ile_ctrl #(
		.CAPACITY   (CAPACITY),
		.DATA_WIDTH (DATA_WIDTH)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.mem_we    (mem_we),
		.mem_waddr (mem_waddr),
		.mem_wdata (mem_wdata),
		.mem_re    (mem_re),
		.mem_raddr (mem_raddr),
		.mem_rdata (mem_rdata),
		.res       (res),
		.res_valid (res_valid),
		.res_ready (res_ready)
	);

	ile_mem #(
		.DEPTH (CAPACITY),
		.WIDTH (DATA_WIDTH)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	// output register, refilled in the cycle the held transaction leaves
	assign res_ready = !out_valid_q || rsp.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_valid && res_ready) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			out_q <= res;
		end
	end

	assign rsp.valid      = out_valid_q;
	assign rsp.read_value = out_q.read_value;
	assign rsp.status     = out_q.status;
	assign rsp.list_count = out_q.list_count;

endmodule
